@@ design/sacl_pkg.sv @@
// Shared types and constants of the set-associative LRU cache directory.
package sacl_pkg;

    localparam int ADDR_W    = 64;
    localparam int TOTAL_W   = 32;
    localparam int OUT_WAY_W = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 6;
    localparam int SBITS_W   = 3;
    localparam int OBITS_W   = 6;
    localparam int WAYS_W    = 4;
    localparam int SHIFT_W   = 7;
    localparam int M_DATA_W  = 104;

    localparam logic [SBITS_W-1:0] SBITS_RESET = 3'd4;
    localparam logic [OBITS_W-1:0] OBITS_RESET = 6'd4;
    localparam logic [WAYS_W-1:0]  WAYS_RESET  = 4'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SET_BITS    = 2'd0,
        CFG_OFFSET_BITS = 2'd1,
        CFG_WAYS        = 2'd2,
        CFG_UNUSED      = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_STORE  = 2'd1,
        MODE_MODIFY = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        OUT_HIT   = 2'd0,
        OUT_FILL  = 2'd1,
        OUT_EVICT = 2'd2
    } outcome_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL,
        ST_SECOND
    } state_t;

    typedef struct packed {
        logic     hit;
        logic     evict;
        outcome_t outcome;
    } sacl_decision_t;

endpackage

@@ design/set_assoc_cache_lru_lookup.sv @@
// Top level of the set-associative tag directory with LRU replacement.
//
// Each input beat is one access: s_tdata carries the 64-bit byte address,
// s_tuser the mode (load, store, modify; the fourth code makes no access
// but still advances the access stamp). The address splits from the bottom
// into offset_bits of block offset, set_index_bits of set index and the
// rest as tag. The whole set (valid, tag and stamp of every way) lives in
// one row of a synchronous RAM: for a load or store the accept cycle
// issues the row read, the next cycle compares all ways, picks hit, first
// empty way or the least recently stamped way, and once the result
// register is free it writes the row back and loads the result register.
// A modify gives two result beats; its second beat is always a hit on the
// same way. An unused-mode beat gives no result beat. A new beat is taken
// while the last result still waits on m_tready; a finished lookup holds
// in place until the result register frees up. After reset, a clearing
// pass writes every set row invalid, one row a cycle; s_tready stays low
// meanwhile, configuration writes are taken.
// Each result beat also reports running hit, miss and eviction totals.
module set_assoc_cache_lru_lookup #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8,
    parameter int STAMP_WIDTH  = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write port
    input  logic                           cfg_wr_en,
    input  logic [sacl_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [sacl_pkg::CFG_DAT_W-1:0] cfg_wdata,
    // access beats
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [63:0]                    s_tdata,  // [63:0] address
    input  logic [1:0]                     s_tuser,  // [1:0] mode
    // result beats
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [1:0] outcome, [4:2] way_used, [36:5] hit_total, [68:37] miss_total,
    // [100:69] eviction_total, [103:101] zero
    output logic [sacl_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                           m_tlast
);

    import sacl_pkg::*;

    localparam int SET_AW  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int SETS    = 2 ** SET_AW;
    localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_W  = $clog2(MAX_WAYS + 1);
    localparam int TAG_OFS = MAX_WAYS;
    localparam int STP_OFS = MAX_WAYS * (1 + ADDR_W);
    localparam int ROW_W   = MAX_WAYS * (1 + ADDR_W + STAMP_WIDTH);

    // configuration
    logic [SBITS_W-1:0] set_bits_reg;
    logic [OBITS_W-1:0] offset_bits_reg;
    logic [WAYS_W-1:0]  ways_reg;

    // control
    state_t state_reg, state_next;
    logic [SET_AW-1:0]      clear_cnt_reg;
    logic [STAMP_WIDTH-1:0] access_cnt_reg;
    logic [TOTAL_W-1:0]     hit_cnt_reg, miss_cnt_reg, evict_cnt_reg;
    logic                   m_tvalid_reg;

    // access in flight
    logic [SET_AW-1:0]      set_reg;
    logic [ADDR_W-1:0]      tag_reg;
    logic [STAMP_WIDTH-1:0] stamp_reg;
    logic                   modify_reg;
    logic [WAY_W-1:0]       way_reg;

    // result payload
    outcome_t               out_outcome_reg;
    logic [OUT_WAY_W-1:0]   out_way_reg;
    logic [TOTAL_W-1:0]     out_hit_reg, out_miss_reg, out_evict_reg;
    logic                   out_last_reg;

    // address split
    logic [SBITS_W-1:0]  sbits_eff;
    logic [WCNT_W-1:0]   ways_eff;
    logic [SET_AW-1:0]   set_mask;
    logic [ADDR_W-1:0]   addr_shifted;
    logic [SET_AW-1:0]   in_set;
    logic [SHIFT_W-1:0]  tag_shift;
    logic [ADDR_W-1:0]   in_tag;

    // handshake and strobes
    logic s_accept;
    logic slot_free;
    logic lookup_go;
    logic commit;
    logic second_go;

    // RAM
    logic              ram_we;
    logic [SET_AW-1:0] ram_waddr;
    logic [ROW_W-1:0]  ram_wdata;
    logic [ROW_W-1:0]  ram_rdata;
    logic [ROW_W-1:0]  row_update;

    logic [MAX_WAYS-1:0]                  row_valid;
    logic [MAX_WAYS-1:0][ADDR_W-1:0]      row_tag;
    logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0] row_stamp;

    sacl_decision_t     decision;
    logic [WAY_W-1:0]   pick_way;
    logic [WAY_W+OUT_WAY_W-1:0] way_ext;
    logic [WAY_W+OUT_WAY_W-1:0] way_reg_ext;

    // Clamp the configured split to what the directory can hold.
    always_comb begin
        if (32'(set_bits_reg) > MAX_SET_BITS) begin
            sbits_eff = SBITS_W'(MAX_SET_BITS);
        end else begin
            sbits_eff = set_bits_reg;
        end
        if (ways_reg == '0) begin
            ways_eff = WCNT_W'(1);
        end else if (32'(ways_reg) > MAX_WAYS) begin
            ways_eff = WCNT_W'(MAX_WAYS);
        end else begin
            ways_eff = WCNT_W'(ways_reg);
        end
    end

    // A full-width shift of one wraps to zero, so the mask becomes all ones.
    assign set_mask     = (SET_AW'(1) << sbits_eff) - SET_AW'(1);
    assign addr_shifted = s_tdata >> offset_bits_reg;
    assign in_set       = (MAX_SET_BITS > 0) ? (addr_shifted[SET_AW-1:0] & set_mask) : '0;
    assign tag_shift    = SHIFT_W'(sbits_eff) + SHIFT_W'(offset_bits_reg);
    // Shifts of 64 or more leave a zero tag.
    assign in_tag       = s_tdata >> tag_shift;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign lookup_go = s_accept && (mode_t'(s_tuser) != MODE_NONE);
    assign slot_free = !m_tvalid_reg || m_tready;
    assign commit    = (state_reg == ST_EVAL) && slot_free;
    assign second_go = (state_reg == ST_SECOND) && slot_free;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clear_cnt_reg == SET_AW'(SETS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (lookup_go) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (slot_free) begin
                    state_next = modify_reg ? ST_SECOND : ST_IDLE;
                end
            end
            ST_SECOND: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // RAM port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = set_reg;
        ram_wdata = row_update;
        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clear_cnt_reg;
                ram_wdata = '0;
            end
            ST_EVAL: begin
                ram_we = slot_free;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Unpack the set row.
    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            row_valid[w] = ram_rdata[w];
            row_tag[w]   = ram_rdata[TAG_OFS + w*ADDR_W +: ADDR_W];
            row_stamp[w] = ram_rdata[STP_OFS + w*STAMP_WIDTH +: STAMP_WIDTH];
        end
    end

    // Refresh the chosen way: valid, tag and the stamp of this access.
    always_comb begin
        row_update = ram_rdata;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (pick_way == WAY_W'(w)) begin
                row_update[w]                                    = 1'b1;
                row_update[TAG_OFS + w*ADDR_W +: ADDR_W]         = tag_reg;
                row_update[STP_OFS + w*STAMP_WIDTH +: STAMP_WIDTH] = stamp_reg;
            end
        end
    end

    sacl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_set_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (lookup_go),
        .raddr (in_set),
        .rdata (ram_rdata)
    );

    sacl_lookup #(
        .MAX_WAYS    (MAX_WAYS),
        .STAMP_WIDTH (STAMP_WIDTH),
        .WAY_W       (WAY_W),
        .WCNT_W      (WCNT_W)
    ) u_lookup (
        .row_valid (row_valid),
        .row_tag   (row_tag),
        .row_stamp (row_stamp),
        .tag       (tag_reg),
        .ways      (ways_eff),
        .decision  (decision),
        .way       (pick_way)
    );

    // Result way keeps its low three bits.
    assign way_ext     = {{OUT_WAY_W{1'b0}}, pick_way};
    assign way_reg_ext = {{OUT_WAY_W{1'b0}}, way_reg};

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clear_cnt_reg   <= '0;
            access_cnt_reg  <= '0;
            hit_cnt_reg     <= '0;
            miss_cnt_reg    <= '0;
            evict_cnt_reg   <= '0;
            m_tvalid_reg    <= 1'b0;
            set_bits_reg    <= SBITS_RESET;
            offset_bits_reg <= OBITS_RESET;
            ways_reg        <= WAYS_RESET;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clear_cnt_reg <= clear_cnt_reg + SET_AW'(1);
            end
            if (cfg_wr_en) begin
                case (cfg_index_t'(cfg_addr))
                    CFG_SET_BITS:    set_bits_reg    <= cfg_wdata[SBITS_W-1:0];
                    CFG_OFFSET_BITS: offset_bits_reg <= cfg_wdata[OBITS_W-1:0];
                    CFG_WAYS:        ways_reg        <= cfg_wdata[WAYS_W-1:0];
                    default:         ;
                endcase
            end
            // Every accepted beat advances the stamp, unused mode included.
            if (s_accept) begin
                access_cnt_reg <= access_cnt_reg + STAMP_WIDTH'(1);
            end
            if (commit) begin
                if (decision.hit) begin
                    hit_cnt_reg <= hit_cnt_reg + TOTAL_W'(1);
                end else begin
                    miss_cnt_reg <= miss_cnt_reg + TOTAL_W'(1);
                end
                if (decision.evict) begin
                    evict_cnt_reg <= evict_cnt_reg + TOTAL_W'(1);
                end
            end
            if (second_go) begin
                hit_cnt_reg <= hit_cnt_reg + TOTAL_W'(1);
            end
            if (commit || second_go) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // access and result payload
    always_ff @(posedge aclk) begin
        if (lookup_go) begin
            set_reg    <= in_set;
            tag_reg    <= in_tag;
            stamp_reg  <= access_cnt_reg + STAMP_WIDTH'(1);
            modify_reg <= (mode_t'(s_tuser) == MODE_MODIFY);
        end
        if (commit) begin
            way_reg         <= pick_way;
            out_outcome_reg <= decision.outcome;
            out_way_reg     <= way_ext[OUT_WAY_W-1:0];
            out_hit_reg     <= hit_cnt_reg + TOTAL_W'(decision.hit);
            out_miss_reg    <= miss_cnt_reg + TOTAL_W'(!decision.hit);
            out_evict_reg   <= evict_cnt_reg + TOTAL_W'(decision.evict);
            out_last_reg    <= !modify_reg;
        end
        // The second access of a modify always hits the way just used.
        if (second_go) begin
            out_outcome_reg <= OUT_HIT;
            out_way_reg     <= way_reg_ext[OUT_WAY_W-1:0];
            out_hit_reg     <= hit_cnt_reg + TOTAL_W'(1);
            out_miss_reg    <= miss_cnt_reg;
            out_evict_reg   <= evict_cnt_reg;
            out_last_reg    <= 1'b1;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {3'b000, out_evict_reg, out_miss_reg, out_hit_reg,
                       out_way_reg, out_outcome_reg};

endmodule

@@ design/sacl_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/sacl_lookup.sv @@
// Set evaluation: tag match, first empty way and LRU victim over one set row.
module sacl_lookup #(
    parameter int MAX_WAYS    = 8,
    parameter int STAMP_WIDTH = 32,
    parameter int WAY_W       = 3,
    parameter int WCNT_W      = 4
) (
    input  logic [MAX_WAYS-1:0]                  row_valid,
    input  logic [MAX_WAYS-1:0][sacl_pkg::ADDR_W-1:0] row_tag,
    input  logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0] row_stamp,
    input  logic [sacl_pkg::ADDR_W-1:0]          tag,
    input  logic [WCNT_W-1:0]                    ways,
    output sacl_pkg::sacl_decision_t             decision,
    output logic [WAY_W-1:0]                     way
);

    import sacl_pkg::*;

    localparam int TREE_LVL = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 0;
    localparam int LEAVES   = 2 ** TREE_LVL;

    logic [MAX_WAYS-1:0] active;
    logic [MAX_WAYS-1:0] hit_vec;
    logic [MAX_WAYS-1:0] empty_vec;
    logic [WAY_W-1:0]    hit_way;
    logic [WAY_W-1:0]    fill_way;

    logic                   node_act   [2*LEAVES];
    logic [WAY_W-1:0]       node_idx   [2*LEAVES];
    logic [STAMP_WIDTH-1:0] node_stamp [2*LEAVES];

    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            active[w]    = (w < int'(ways));
            hit_vec[w]   = active[w] && row_valid[w] && (row_tag[w] == tag);
            empty_vec[w] = active[w] && !row_valid[w];
        end
    end

    // Priority encoders: lowest way wins.
    always_comb begin
        hit_way  = '0;
        fill_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w]) begin
                hit_way = WAY_W'(w);
            end
            if (empty_vec[w]) begin
                fill_way = WAY_W'(w);
            end
        end
    end

    // Min tree; on equal stamps keep the left (lower) way.
    always_comb begin
        for (int i = 0; i < 2 * LEAVES; i++) begin
            node_act[i]   = 1'b0;
            node_idx[i]   = '0;
            node_stamp[i] = '0;
        end
        for (int i = 0; i < MAX_WAYS; i++) begin
            node_act[LEAVES + i]   = active[i];
            node_idx[LEAVES + i]   = WAY_W'(i);
            node_stamp[LEAVES + i] = row_stamp[i];
        end
        for (int i = LEAVES - 1; i >= 1; i--) begin
            if (!node_act[2*i] ||
                (node_act[2*i+1] && (node_stamp[2*i] > node_stamp[2*i+1]))) begin
                node_act[i]   = node_act[2*i+1];
                node_idx[i]   = node_idx[2*i+1];
                node_stamp[i] = node_stamp[2*i+1];
            end else begin
                node_act[i]   = node_act[2*i];
                node_idx[i]   = node_idx[2*i];
                node_stamp[i] = node_stamp[2*i];
            end
        end
    end

    always_comb begin
        decision.hit   = |hit_vec;
        decision.evict = 1'b0;
        if (|hit_vec) begin
            decision.outcome = OUT_HIT;
            way              = hit_way;
        end else if (|empty_vec) begin
            decision.outcome = OUT_FILL;
            way              = fill_way;
        end else begin
            decision.outcome = OUT_EVICT;
            decision.evict   = 1'b1;
            way              = node_idx[1];
        end
    end

endmodule

@@ design/sacl_checker.sv @@
// Port-level checks of the cache directory, bound to the top level.
module sacl_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [1:0]                    s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [sacl_pkg::M_DATA_W-1:0] m_tdata,
    input logic                          m_tlast
);

    import sacl_pkg::*;

    // A stalled result beat holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result beat changed");

    // A real access blocks the input for its lookup cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser != MODE_NONE) |=> !s_tready)
        else $error("input taken during lookup");

    // The second beat of a modify follows at once and is a hit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && m_tlast && (m_tdata[1:0] == OUT_HIT))
        else $error("modify second beat missing or not a hit");

    // An eviction is counted in the totals of its own beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == OUT_EVICT) |->
            (m_tdata[100:69] != '0) && (m_tdata[68:37] != '0))
        else $error("eviction beat with zero totals");

endmodule

bind set_assoc_cache_lru_lookup sacl_checker u_sacl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

@@ test/set_assoc_cache_lru_lookup_test.sv @@
// Self-checking testbench for the set-associative LRU tag directory.
module set_assoc_cache_lru_lookup_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sacl_pkg::*;

    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 10;
    localparam int MAX_SET_BITS    = 6;
    localparam int MAX_WAYS        = 8;
    localparam int NUM_LINES       = (1 << MAX_SET_BITS) * MAX_WAYS;
    localparam int IDLE_PCT        = 6;
    // a few cycles past the last result: covers an unused-mode beat still in flight
    localparam int DRAIN_CYCLES    = 8;
    // no beat moves for this many cycles: the block is hung
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int PHASES          = 12;
    localparam int BEATS_PER_PHASE = 158;
    localparam int QUIET_PHASE     = 5;

    // one result beat as the block should send it
    typedef struct {
        outcome_t    outcome;
        logic [2:0]  way;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [31:0] evicts;
        logic        last;
    } lookup_result_t;

    typedef enum { ROW_ACCESS, ROW_WRITE } row_kind_t;

    // one row of the directed table: an access or a register write
    typedef struct {
        row_kind_t  kind;
        logic [63:0] addr;
        mode_t      mode;
        cfg_index_t reg_idx;
        logic [5:0] value;
        bit         typed;      // outcome and way of the first result typed in
        outcome_t   t_outcome;
        logic [2:0] t_way;
    } stim_row_t;

    // ---------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero
    // ---------------------------------------------------------------
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr  = CFG_SET_BITS;
    logic [5:0]  cfg_wdata = '0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;   // [63:0] address
    logic [1:0]  s_tuser  = MODE_LOAD; // [1:0] mode

    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // [1:0] outcome, [4:2] way_used, [36:5] hit_total, [68:37] miss_total,
    // [100:69] eviction_total, [103:101] zero
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;

    always #CLK_HALF aclk = ~aclk;

    set_assoc_cache_lru_lookup DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // ---------------------------------------------------------------
    // Directory shadow: valid, tag and stamp per line, plus the
    // running totals and the register copies
    // ---------------------------------------------------------------
    logic        line_valid [NUM_LINES];
    logic [63:0] line_tag   [NUM_LINES];
    logic [31:0] line_stamp [NUM_LINES];
    logic [31:0] stamp_now  = '0;
    logic [31:0] hit_cnt    = '0;
    logic [31:0] miss_cnt   = '0;
    logic [31:0] evict_cnt  = '0;
    logic [2:0]  cur_sbits  = SBITS_RESET;
    logic [5:0]  cur_obits  = OBITS_RESET;
    logic [3:0]  cur_ways   = WAYS_RESET;

    lookup_result_t expected_results[$];
    stim_row_t      directed_rows[$];

    int  fail_count   = 0;
    int  beats_sent   = 0;
    int  results_seen = 0;
    int  hits_seen    = 0;
    int  evicts_seen  = 0;
    int  writes_done  = 0;
    int  stall_cycles = 0;
    bit  quiet        = 1'b0;   // no idling on either side while set

    initial begin
        for (int i = 0; i < NUM_LINES; i++) line_valid[i] = 1'b0;
    end

    // One lookup in the set starting at line base. A tag or stamp is
    // only ever read for a valid line.
    function automatic lookup_result_t probe_set(int base, logic [63:0] tag,
                                                 logic [31:0] stamp, int nways);
        lookup_result_t r;
        int  way;
        int  victim;
        bit  hit;
        bit  filled;
        way    = 0;
        victim = 0;
        hit    = 1'b0;
        filled = 1'b0;
        for (int w = 0; w < nways; w++) begin
            if (!hit && line_valid[base + w] && line_tag[base + w] == tag) begin
                hit = 1'b1;
                way = w;
            end
        end
        if (hit) begin
            line_stamp[base + way] = stamp;
            hit_cnt   = hit_cnt + 1;
            r.outcome = OUT_HIT;
        end else begin
            miss_cnt = miss_cnt + 1;
            // first empty way wins; otherwise the oldest stamp, lowest way on a tie
            for (int w = 0; w < nways; w++) begin
                if (!filled) begin
                    if (!line_valid[base + w]) begin
                        way    = w;
                        filled = 1'b1;
                    end else if (line_stamp[base + victim] > line_stamp[base + w]) begin
                        victim = w;
                    end
                end
            end
            if (filled) begin
                r.outcome = OUT_FILL;
            end else begin
                way       = victim;
                evict_cnt = evict_cnt + 1;
                r.outcome = OUT_EVICT;
            end
            line_valid[base + way] = 1'b1;
            line_tag[base + way]   = tag;
            line_stamp[base + way] = stamp;
        end
        r.way    = way[2:0];
        r.hits   = hit_cnt;
        r.misses = miss_cnt;
        r.evicts = evict_cnt;
        r.last   = 1'b0;
        return r;
    endfunction

    // Work out and queue the result beats of one accepted access beat.
    function automatic void predict_access(logic [63:0] addr, mode_t mode, bit typed,
                                           outcome_t t_oc, logic [2:0] t_way);
        int  sb;
        int  nways;
        int  shift;
        int  base;
        logic [63:0] tag;
        lookup_result_t r;
        sb    = (cur_sbits > MAX_SET_BITS) ? MAX_SET_BITS : int'(cur_sbits);
        nways = (cur_ways == 0) ? 1 : ((cur_ways > MAX_WAYS) ? MAX_WAYS : int'(cur_ways));
        // the stamp advances on every beat, the unused mode included
        stamp_now = stamp_now + 1;
        if (mode == MODE_NONE) return;
        base  = int'((addr >> cur_obits) & ((64'd1 << sb) - 64'd1)) * MAX_WAYS;
        shift = sb + int'(cur_obits);
        tag   = (shift >= 64) ? 64'd0 : (addr >> shift);
        r = probe_set(base, tag, stamp_now, nways);
        if (typed) begin
            r.outcome = t_oc;
            r.way     = t_way;
        end
        r.last = (mode != MODE_MODIFY);
        expected_results.push_back(r);
        if (mode == MODE_MODIFY) begin
            // second access of a modify reuses the same stamp
            r      = probe_set(base, tag, stamp_now, nways);
            r.last = 1'b1;
            expected_results.push_back(r);
        end
    endfunction

    // ---------------------------------------------------------------
    // Directed table helpers
    // ---------------------------------------------------------------
    function automatic void add_access(logic [63:0] addr, mode_t mode, bit typed = 1'b0,
                                       outcome_t oc = OUT_HIT, logic [2:0] way = 3'd0);
        stim_row_t r;
        r.kind      = ROW_ACCESS;
        r.addr      = addr;
        r.mode      = mode;
        r.reg_idx   = CFG_UNUSED;
        r.value     = '0;
        r.typed     = typed;
        r.t_outcome = oc;
        r.t_way     = way;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_write(cfg_index_t idx, logic [5:0] value);
        stim_row_t r;
        r.kind      = ROW_WRITE;
        r.addr      = '0;
        r.mode      = MODE_LOAD;
        r.reg_idx   = idx;
        r.value     = value;
        r.typed     = 1'b0;
        r.t_outcome = OUT_HIT;
        r.t_way     = '0;
        directed_rows.push_back(r);
    endfunction

    // ---------------------------------------------------------------
    // Access side: random idle cycles, then hold the beat until taken
    // ---------------------------------------------------------------
    task automatic send_beat(logic [63:0] addr, mode_t mode, bit typed,
                             outcome_t t_oc, logic [2:0] t_way);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= addr;
        s_tuser  <= mode;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_access(addr, mode, typed, t_oc, t_way);
        beats_sent++;
    endtask

    // Write one register once the block has gone quiet.
    task automatic write_reg(cfg_index_t idx, logic [5:0] value);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_SET_BITS:    cur_sbits = value[2:0];
            CFG_OFFSET_BITS: cur_obits = value;
            CFG_WAYS:        cur_ways  = value[3:0];
            default:         ;
        endcase
        writes_done++;
    endtask

    // ---------------------------------------------------------------
    // Result side: check every beat against the oldest expectation
    // ---------------------------------------------------------------
    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result_beat();
        lookup_result_t want;
        if (expected_results.size() == 0) begin
            $display("%0t: result beat with nothing expected, actual data %h last %b",
                     $time, m_tdata, m_tlast);
            fail_count++;
        end else begin
            want = expected_results.pop_front();
            compare_field("outcome",        32'(want.outcome), 32'(m_tdata[1:0]));
            compare_field("way_used",       32'(want.way),     32'(m_tdata[4:2]));
            compare_field("hit_total",      want.hits,         m_tdata[36:5]);
            compare_field("miss_total",     want.misses,       m_tdata[68:37]);
            compare_field("eviction_total", want.evicts,       m_tdata[100:69]);
            compare_field("pad",            32'd0,             32'(m_tdata[103:101]));
            compare_field("last",           32'(want.last),    32'(m_tlast));
            if (want.outcome == OUT_HIT) hits_seen++;
            if (want.outcome == OUT_EVICT) evicts_seen++;
        end
        results_seen++;
    endtask

    // sample at the edge, then pick the next ready value
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_result_beat();
        m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end

    // Watchdog: end the run if no beat and no write moves for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles, %0d results still due",
                     $time, WATCHDOG_LIMIT, expected_results.size());
            $display("*** FAILED ***");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial begin
        int          sb;
        int          sb_eff;
        int          ob;
        int          wy;
        int          ways_eff;
        int          shift;
        int          nsets;
        int          ntags;
        logic [63:0] set_pool [4];
        logic [63:0] tag_pool [12];
        logic [63:0] addr;
        mode_t       mode;

        // Directed table, starting at the reset split (4 set bits,
        // 4 offset bits, one way).
        add_access(64'h0, MODE_LOAD, 1'b1, OUT_FILL, 3'd0);    // empty after reset
        add_access(64'h0, MODE_LOAD, 1'b1, OUT_HIT, 3'd0);
        add_access(64'hFFFF_FFFF_FFFF_FFFF, MODE_STORE, 1'b1, OUT_FILL, 3'd0);
        add_access(64'hFFFF_FFFF_FFFF_FFFF, MODE_MODIFY, 1'b1, OUT_HIT, 3'd0);
        add_access(64'h100, MODE_LOAD, 1'b1, OUT_EVICT, 3'd0); // one way: evict
        add_access(64'h0, MODE_MODIFY, 1'b1, OUT_EVICT, 3'd0); // evict, then hit
        add_access(64'h55, MODE_NONE);                         // no access, stamp moves
        add_access(64'h8, MODE_LOAD, 1'b1, OUT_HIT, 3'd0);     // offset bits ignored
        add_write(CFG_WAYS, 6'd0);                             // zero ways acts as one
        add_access(64'h200, MODE_LOAD, 1'b1, OUT_EVICT, 3'd0);
        add_write(CFG_WAYS, 6'd15);                            // clamps to eight ways
        add_access(64'h300, MODE_LOAD, 1'b1, OUT_FILL, 3'd1);
        add_access(64'h400, MODE_LOAD, 1'b1, OUT_FILL, 3'd2);
        add_write(CFG_SET_BITS, 6'd7);                         // saturates at six
        add_access(64'h3F0, MODE_LOAD, 1'b1, OUT_FILL, 3'd0);
        add_write(CFG_OFFSET_BITS, 6'd63);                     // split past the top: tag 0
        add_access(64'h8000_0000_0000_0000, MODE_LOAD, 1'b1, OUT_FILL, 3'd0);
        add_access(64'h0, MODE_LOAD);
        add_access(64'hFFFF_FFFF_FFFF_FFFF, MODE_MODIFY, 1'b1, OUT_HIT, 3'd0);
        add_write(CFG_OFFSET_BITS, 6'd0);
        add_write(CFG_SET_BITS, 6'd0);
        add_write(CFG_UNUSED, 6'd63);                          // must change nothing
        add_access(64'hFFFF_FFFF_FFFF_FFFF, MODE_LOAD);
        add_access(64'h0, MODE_STORE);
        add_access(64'h5555_5555_5555_5555, MODE_MODIFY);
        add_access(64'hAAAA_AAAA_AAAA_AAAA, MODE_NONE);

        // hold reset, then release once
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // walk the table; the clearing pass holds s_tready low meanwhile
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_WRITE)
                write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
            else
                send_beat(directed_rows[i].addr, directed_rows[i].mode,
                          directed_rows[i].typed, directed_rows[i].t_outcome,
                          directed_rows[i].t_way);
        end

        // Random phases: each picks a split and a way count, then
        // replays a small pool of sets and tags so hits, fills and LRU
        // evictions all show up; a slice of beats are fully random.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin sb = 0; ob = 0;  wy = 1;  end
                1: begin sb = 7; ob = 63; wy = 15; end
                2: begin sb = 6; ob = 32; wy = 8;  end
                3: begin sb = 1; ob = 58; wy = 0;  end
                default: begin
                    sb = $urandom_range(0, 7);
                    ob = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                      : $urandom_range(0, 12);
                    wy = $urandom_range(0, 15);
                end
            endcase
            write_reg(CFG_SET_BITS, 6'(sb));
            write_reg(CFG_OFFSET_BITS, 6'(ob));
            write_reg(CFG_WAYS, 6'(wy));
            quiet = (p == QUIET_PHASE);

            sb_eff   = (sb > MAX_SET_BITS) ? MAX_SET_BITS : sb;
            ways_eff = (wy == 0) ? 1 : ((wy > MAX_WAYS) ? MAX_WAYS : wy);
            shift    = sb_eff + ob;
            nsets    = $urandom_range(1, 4);
            ntags    = ways_eff + $urandom_range(1, 3);
            for (int k = 0; k < nsets; k++)
                set_pool[k] = 64'($urandom_range(0, (1 << sb_eff) - 1));
            for (int k = 0; k < ntags; k++)
                tag_pool[k] = {$urandom, $urandom};

            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                if ($urandom_range(99) < 12) begin
                    addr = {$urandom, $urandom};
                end else begin
                    addr = (tag_pool[$urandom_range(0, ntags - 1)] << shift)
                         | (set_pool[$urandom_range(0, nsets - 1)] << ob)
                         | ({$urandom, $urandom} & ((64'd1 << ob) - 64'd1));
                end
                if ($urandom_range(99) < 8)
                    mode = MODE_NONE;
                else
                    mode = mode_t'($urandom_range(0, 2));
                send_beat(addr, mode, 1'b0, OUT_HIT, 3'd0);
            end
        end
        quiet = 1'b0;

        // drain: everything expected must come back, then a short tail
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (2 * DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d access beats and %0d register writes over %0d settings;",
                 beats_sent, writes_done, PHASES + 4);
        $display("checked %0d result beats, %0d of them hits and %0d evictions.",
                 results_seen, hits_seen, evicts_seen);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ files.f @@
design/sacl_pkg.sv
design/sacl_ram.sv
design/sacl_lookup.sv
design/set_assoc_cache_lru_lookup.sv
design/sacl_checker.sv
test/set_assoc_cache_lru_lookup_test.sv
